FILE: sv/spfa_longest_path_engine_core_macros.svh
// Assertion macros for the SPFA longest-path engine checker.
// Used by the bind checker only.
`ifndef SPFA_LONGEST_PATH_ENGINE_CORE_MACROS_SVH
`define SPFA_LONGEST_PATH_ENGINE_CORE_MACROS_SVH
// implication checked every clock outside reset
`define SLP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication checked every clock outside reset
`define SLP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: sv/slpe_pkg.sv
// Package for the SPFA longest-path engine: sizes, payload structs, queue entry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slpe_pkg;
   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 4096;
   localparam int WEIGHT_BITS = 8;
   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int EDGE_BITS = $clog2(MAX_EDGES);
   localparam int LINK_BITS = EDGE_BITS + 1;
   localparam int SUM_BITS = 48;
   localparam int CMD_ADD = 0;
   localparam int CMD_SOLVE = 1;

   typedef struct packed {
      logic       cmd;
      logic [9:0] src_node;
      logic [9:0] dst_node;
      logic [7:0] weight;
   } req_type;

   typedef struct packed {
      logic        positive_cycle;
      logic [47:0] distance_sum;
      logic        edge_overflow;
   } rsp_type;

   typedef struct packed {
      logic                   is_solve;
      logic [NODE_BITS-1:0]   src;
      logic [NODE_BITS-1:0]   dst;
      logic [WEIGHT_BITS-1:0] wt;
   } cmd_type;
endpackage
`default_nettype wire

FILE: sv/slpe_front.sv
// Front end: accepts request beats, filters out-of-range edges, feeds a two-entry queue.
// Depends on slpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slpe_front import slpe_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         q_valid,
   input  wire logic    q_ready,
   output cmd_type      q_data
);
   cmd_type    mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop, keep;
   cmd_type    ent;

   assign req_ready = (cnt_ff != 2'd2);
   // drop edges that name nodes beyond the store
   assign keep = (req_data.cmd == 1'(CMD_SOLVE)) ||
                 ((32'(req_data.src_node) < MAX_NODES) && (32'(req_data.dst_node) < MAX_NODES));
   assign push = req_valid && req_ready && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign pop = q_valid && q_ready;
   assign q_data = mem_ff[rp_ff];
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_comb begin
      ent.is_solve = (req_data.cmd == 1'(CMD_SOLVE));
      ent.src = NODE_BITS'(req_data.src_node);
      ent.dst = NODE_BITS'(req_data.dst_node);
      ent.wt = WEIGHT_BITS'(req_data.weight);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= ent;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
   end
endmodule
`default_nettype wire

FILE: sv/slpe_back.sv
// Back end: edge stores, SPFA sequencer, summation, result register.
// Depends on slpe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slpe_back import slpe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [9:0] node_count,
   input  wire logic       q_valid,
   output logic            q_ready,
   input  wire cmd_type    q_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);
   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_CLR   = 12'b000000000010,
      S_POP   = 12'b000000000100,
      S_VIS   = 12'b000000001000,
      S_HEAD  = 12'b000000010000,
      S_EDGE  = 12'b000000100000,
      S_DST   = 12'b000001000000,
      S_RELAX = 12'b000010000000,
      S_SUMRD = 12'b000100000000,
      S_SUM   = 12'b001000000000,
      S_DONE  = 12'b010000000000,
      S_ADD   = 12'b100000000000
   } state_type;

   localparam int DIST_BITS = 20;
   localparam int VIS_BITS = NODE_BITS + 1;

   logic [LINK_BITS-1:0]   head_mem [MAX_NODES];
   logic [NODE_BITS-1:0]   dest_mem [MAX_EDGES];
   logic [WEIGHT_BITS-1:0] wt_mem   [MAX_EDGES];
   logic [LINK_BITS-1:0]   link_mem [MAX_EDGES];
   logic [DIST_BITS-1:0]   dist_mem [MAX_NODES];
   logic [VIS_BITS-1:0]    vis_mem  [MAX_NODES];
   logic                   qf_mem   [MAX_NODES];
   logic [NODE_BITS-1:0]   fifo_mem [MAX_NODES];

   state_type            st_ff;
   logic [LINK_BITS-1:0] total_ff;
   logic                 ovf_ff;
   logic [NODE_BITS-1:0] hclr_ff;
   logic                 hclr_done_ff;
   logic [NODE_BITS-1:0] idx_ff;
   logic [NODE_BITS-1:0] x_ff, y_ff;
   logic [DIST_BITS-1:0] dx_ff, cand_ff;
   logic [LINK_BITS-1:0] e_ff;
   logic [NODE_BITS-1:0] rd_ff, wr_ff;
   logic [NODE_BITS:0]   cnt_ff;
   logic [9:0]           lim_ff;
   logic [NODE_BITS-1:0] top_ff;
   logic [SUM_BITS-1:0]  sum_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [LINK_BITS-1:0]   head_rd;
   logic [NODE_BITS-1:0]   dest_rd, fifo_rd;
   logic [WEIGHT_BITS-1:0] wt_rd;
   logic [LINK_BITS-1:0]   link_rd;
   logic [DIST_BITS-1:0]   dist_rd;
   logic [VIS_BITS-1:0]    vis_rd;
   logic                   qf_rd;

   logic [9:0] n_eff;
   assign n_eff = (node_count == 10'd0) ? 10'd1 : node_count;
   assign q_ready = hclr_done_ff &&
                    ((st_ff == S_ADD) ||
                     ((st_ff == S_IDLE) && q_data.is_solve && !rsp_valid_ff));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   wire add_go = q_valid && q_ready && !q_data.is_solve;
   wire sol_go = q_valid && q_ready && q_data.is_solve;
   wire full = (32'(total_ff) >= MAX_EDGES);
   wire [EDGE_BITS-1:0] ek = EDGE_BITS'(e_ff - 1'b1);

   // head store: cleared by a sweep after reset, then read/written
   always_ff @(posedge clock) begin
      if (!hclr_done_ff) head_mem[hclr_ff] <= '0;
      else if (add_go && !full) head_mem[q_data.src] <= total_ff + 1'b1;
      head_rd <= head_mem[(st_ff == S_POP) ? fifo_rd : q_data.src];
   end

   always_ff @(posedge clock) begin
      if (add_go && !full) begin
         dest_mem[EDGE_BITS'(total_ff)] <= q_data.dst;
         wt_mem[EDGE_BITS'(total_ff)] <= q_data.wt;
         link_mem[EDGE_BITS'(total_ff)] <= head_rd;
      end
      dest_rd <= dest_mem[ek];
      wt_rd <= wt_mem[ek];
      link_rd <= link_mem[ek];
   end

   // per-node solve stores
   logic [NODE_BITS-1:0] nd_addr;
   always_comb begin
      unique case (st_ff)
         S_CLR:   nd_addr = idx_ff;
         S_POP:   nd_addr = fifo_rd;
         S_SUMRD: nd_addr = idx_ff;
         S_SUM:   nd_addr = idx_ff;
         default: nd_addr = y_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_CLR) begin
         dist_mem[idx_ff] <= '0;
         vis_mem[idx_ff] <= (idx_ff == '0) ? VIS_BITS'(1) : '0;
         qf_mem[idx_ff] <= (idx_ff == '0);
      end else if (st_ff == S_VIS && vis_rd != VIS_BITS'(lim_ff)) begin
         vis_mem[x_ff] <= vis_rd + 1'b1;
         qf_mem[x_ff] <= 1'b0;
      end else if (st_ff == S_RELAX && dist_rd < cand_ff) begin
         dist_mem[y_ff] <= cand_ff;
         if (!qf_rd && 32'(cnt_ff) < MAX_NODES) qf_mem[y_ff] <= 1'b1;
      end
      dist_rd <= dist_mem[nd_addr];
      vis_rd <= vis_mem[nd_addr];
      qf_rd <= qf_mem[nd_addr];
   end

   always_ff @(posedge clock) begin
      if (st_ff == S_CLR && idx_ff == '0) fifo_mem[0] <= '0;
      else if (st_ff == S_RELAX && dist_rd < cand_ff && !qf_rd && 32'(cnt_ff) < MAX_NODES)
         fifo_mem[wr_ff] <= y_ff;
      fifo_rd <= fifo_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         total_ff <= '0;
         ovf_ff <= 1'b0;
         hclr_ff <= '0;
         hclr_done_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!hclr_done_ff) begin
            hclr_ff <= hclr_ff + 1'b1;
            if (32'(hclr_ff) == MAX_NODES - 1) hclr_done_ff <= 1'b1;
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (add_go) begin
            if (full) ovf_ff <= 1'b1;
            else total_ff <= total_ff + 1'b1;
         end
         unique case (st_ff)
            S_IDLE: begin
               if (sol_go) begin
                  st_ff <= S_CLR;
                  idx_ff <= '0;
                  lim_ff <= n_eff - 10'd1;
                  top_ff <= (32'(n_eff) < MAX_NODES) ? NODE_BITS'(n_eff)
                                                     : NODE_BITS'(MAX_NODES - 1);
                  rd_ff <= '0;
                  wr_ff <= NODE_BITS'(1);
                  cnt_ff <= (NODE_BITS+1)'(1);
               end else if (hclr_done_ff && q_valid && !q_data.is_solve) begin
                  // read the list head first, link and store next cycle
                  st_ff <= S_ADD;
               end
            end
            S_ADD: st_ff <= S_IDLE;
            S_CLR: begin
               idx_ff <= idx_ff + 1'b1;
               if (32'(idx_ff) == MAX_NODES - 1) st_ff <= S_POP;
            end
            S_POP: begin
               // fifo_rd valid here; node stores and head read it
               if (cnt_ff == '0) begin
                  st_ff <= S_SUMRD;
                  idx_ff <= NODE_BITS'(1);
                  sum_ff <= '0;
               end else begin
                  x_ff <= fifo_rd;
                  rd_ff <= rd_ff + 1'b1;
                  cnt_ff <= cnt_ff - 1'b1;
                  st_ff <= S_VIS;
               end
            end
            S_VIS: begin
               if (vis_rd == VIS_BITS'(lim_ff)) begin
                  rsp_ff.positive_cycle <= 1'b1;
                  rsp_ff.distance_sum <= '0;
                  rsp_ff.edge_overflow <= ovf_ff;
                  st_ff <= S_DONE;
               end else begin
                  dx_ff <= dist_rd;
                  e_ff <= head_rd;
                  st_ff <= S_HEAD;
               end
            end
            S_HEAD: begin
               if (e_ff == '0 || 32'(e_ff) > MAX_EDGES) st_ff <= S_POP;
               else st_ff <= S_EDGE;
            end
            S_EDGE: begin
               y_ff <= dest_rd;
               cand_ff <= dx_ff + DIST_BITS'(wt_rd);
               e_ff <= link_rd;
               st_ff <= S_DST;
            end
            S_DST: st_ff <= S_RELAX;
            S_RELAX: begin
               if (dist_rd < cand_ff && !qf_rd && 32'(cnt_ff) < MAX_NODES) begin
                  wr_ff <= wr_ff + 1'b1;
                  cnt_ff <= cnt_ff + 1'b1;
               end
               // a self-loop raises the distance used by the rest of the list
               if (dist_rd < cand_ff && y_ff == x_ff) dx_ff <= cand_ff;
               st_ff <= S_HEAD;
            end
            S_SUMRD: st_ff <= S_SUM;
            S_SUM: begin
               sum_ff <= sum_ff + SUM_BITS'(dist_rd);
               if (idx_ff == top_ff) begin
                  rsp_ff.positive_cycle <= 1'b0;
                  rsp_ff.distance_sum <= sum_ff + SUM_BITS'(dist_rd);
                  rsp_ff.edge_overflow <= ovf_ff;
                  st_ff <= S_DONE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  st_ff <= S_SUMRD;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: sv/spfa_longest_path_engine_core.sv
// SPFA longest-path engine with positive-cycle detection. An add beat stores one
// edge in two steps (list-head read, then link and store) before the back end takes
// a new beat; beats wait in the two-entry front queue. A solve beat sweeps the
// 1024-entry node stores, then walks the work queue: each dequeue runs the pop,
// visit and head states, each edge the edge, dest, relax and head states. Unless it
// finds a positive cycle, each node is read and summed; a done state posts the
// result. A solve waits while an earlier result is unaccepted. After reset a sweep
// clears the list-head memory; the front queue takes at most two beats meanwhile.
// Depends on slpe_pkg, slpe_front, slpe_back.
`timescale 1ns / 1ps
`default_nettype none
module spfa_longest_path_engine_core import slpe_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [9:0] csr_wdata
);
   logic [9:0] ncount_ff;
   logic       q_valid, q_ready;
   cmd_type    q_data;

   always_ff @(posedge clock) begin
      if (reset) ncount_ff <= 10'd1023;
      else if (csr_we) ncount_ff <= csr_wdata;
   end

   slpe_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   slpe_back u_back (
      .clock(clock), .reset(reset), .node_count(ncount_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

FILE: sv/spfa_longest_path_engine_core_checker.sv
// Port-level checker for the SPFA longest-path engine, bound to the top level.
// Depends on slpe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "spfa_longest_path_engine_core_macros.svh"
module spfa_longest_path_engine_core_checker import slpe_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);
   logic req_stall, rsp_stall, rsp_ovf_beat;
   assign req_stall = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_ovf_beat = rsp_valid && rsp_ready && rsp_data.edge_overflow;

   `SLP_ASSERT_NXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_data), "req beat changed")
   `SLP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed")
   `SLP_ASSERT_IMP(a_cyc_zero, clock, reset, rsp_valid && rsp_data.positive_cycle, rsp_data.distance_sum == '0, "cycle with sum")
   `SLP_ASSERT_NXT(a_ovf_sticky, clock, reset, rsp_ovf_beat, !rsp_valid || rsp_data.edge_overflow, "overflow cleared")
endmodule
bind spfa_longest_path_engine_core spfa_longest_path_engine_core_checker u_checker (.*);
`default_nettype wire

FILE: test/tb_spfa_longest_path_engine_core.sv
// Self-checking testbench for spfa_longest_path_engine_core: directed table, then random
// edge and solve beats, checked against listed results or an in-bench longest-path predictor.
// Depends on slpe_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_spfa_longest_path_engine_core;
   import slpe_pkg::*;

   typedef struct {
      bit        is_cfg;
      bit [9:0]  cfg_val;
      req_type   item;
      bit        typed;
      rsp_type   want;
   } step_type;

   localparam int WATCHDOG_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 100;

   logic clock = 0;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [9:0] csr_wdata;

   spfa_longest_path_engine_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   int unsigned node_limit_reg;
   int unsigned head_of[MAX_NODES];
   int unsigned dest_of[MAX_EDGES];
   int unsigned wt_of[MAX_EDGES];
   int unsigned link_of[MAX_EDGES];
   int unsigned edges_stored;
   bit dropped_edge;
   longint unsigned path_len[MAX_NODES];
   int unsigned pops[MAX_NODES];
   bit in_queue[MAX_NODES];

   rsp_type pending_rsp[$];
   int errors = 0;
   int idle_cycles = 0;
   int rsp_wait = 0;
   bit quiet = 0;
   step_type steps[$];

   function automatic void store_edge(int unsigned s, int unsigned d, int unsigned w);
      if (edges_stored >= MAX_EDGES) begin
         dropped_edge = 1;
         return;
      end
      dest_of[edges_stored] = d;
      wt_of[edges_stored] = w & ((1 << WEIGHT_BITS) - 1);
      link_of[edges_stored] = head_of[s];
      edges_stored++;
      head_of[s] = edges_stored;
   endfunction

   function automatic rsp_type run_solve();
      int unsigned n, lim, x, e, k, y, top;
      longint unsigned cand, sum;
      int unsigned fifo[$];
      bit cyc;
      rsp_type r;
      n = (node_limit_reg == 0) ? 1 : node_limit_reg;
      lim = n - 1;
      cyc = 0;
      sum = 0;
      for (int i = 0; i < MAX_NODES; i++) begin
         path_len[i] = 0;
         pops[i] = 0;
         in_queue[i] = 0;
      end
      pops[0] = 1;
      in_queue[0] = 1;
      fifo.push_back(0);
      while (fifo.size() != 0 && !cyc) begin
         x = fifo.pop_front();
         in_queue[x] = 0;
         if (pops[x] == lim) begin
            cyc = 1;
         end else begin
            pops[x]++;
            e = head_of[x];
            while (e != 0) begin
               k = e - 1;
               y = dest_of[k];
               cand = path_len[x] + wt_of[k];
               if (path_len[y] < cand) begin
                  path_len[y] = cand;
                  if (!in_queue[y] && fifo.size() < MAX_NODES) begin
                     in_queue[y] = 1;
                     fifo.push_back(y);
                  end
               end
               e = link_of[k];
            end
         end
      end
      if (!cyc) begin
         top = (n < MAX_NODES) ? n : MAX_NODES - 1;
         for (int unsigned i = 1; i <= top; i++) sum += path_len[i];
      end
      r.positive_cycle = cyc;
      r.distance_sum = cyc ? 48'd0 : sum[47:0];
      r.edge_overflow = dropped_edge;
      return r;
   endfunction

   function automatic step_type row_add(int unsigned s, int unsigned d, int unsigned w);
      step_type t;
      t = '{default: 0};
      t.item.cmd = 1'(CMD_ADD);
      t.item.src_node = 10'(s);
      t.item.dst_node = 10'(d);
      t.item.weight = 8'(w);
      return t;
   endfunction

   function automatic step_type row_solve(bit typed, bit pc, longint unsigned sum, bit ov);
      step_type t;
      t = '{default: 0};
      t.item.cmd = 1'(CMD_SOLVE);
      t.item.src_node = 10'($urandom_range(0, 1023));
      t.item.dst_node = 10'($urandom_range(0, 1023));
      t.item.weight = 8'($urandom_range(0, 255));
      t.typed = typed;
      t.want.positive_cycle = pc;
      t.want.distance_sum = sum[47:0];
      t.want.edge_overflow = ov;
      return t;
   endfunction

   function automatic step_type row_cfg(int unsigned v);
      step_type t;
      t = '{default: 0};
      t.is_cfg = 1;
      t.cfg_val = 10'(v);
      return t;
   endfunction

   task automatic write_node_count(int unsigned v);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      csr_we <= 1;
      csr_wdata <= 10'(v);
      @(posedge clock);
      csr_we <= 0;
      node_limit_reg = v;
   endtask

   task automatic send_beat(req_type r, bit typed, rsp_type want);
      int gap;
      rsp_type got;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      if (r.cmd == 1'(CMD_SOLVE)) begin
         got = run_solve();
         pending_rsp.push_back(typed ? want : got);
      end else begin
         store_edge(r.src_node, r.dst_node, r.weight);
      end
   endtask

   task automatic run_step(step_type t);
      if (t.is_cfg) begin
         req_valid <= 0;
         write_node_count(t.cfg_val);
      end else begin
         send_beat(t.item, t.typed, t.want);
      end
   endtask

   always @(posedge clock) begin
      int w;
      rsp_type exp_r;
      if (reset) begin
         rsp_ready <= 0;
         rsp_wait <= 0;
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected result beat");
               errors++;
            end else begin
               exp_r = pending_rsp.pop_front();
               if (rsp_data.positive_cycle !== exp_r.positive_cycle) begin
                  $error("positive_cycle exp %0d got %0d", exp_r.positive_cycle,
                         rsp_data.positive_cycle);
                  errors++;
               end
               if (rsp_data.distance_sum !== exp_r.distance_sum) begin
                  $error("distance_sum exp %0d got %0d", exp_r.distance_sum,
                         rsp_data.distance_sum);
                  errors++;
               end
               if (rsp_data.edge_overflow !== exp_r.edge_overflow) begin
                  $error("edge_overflow exp %0d got %0d", exp_r.edge_overflow,
                         rsp_data.edge_overflow);
                  errors++;
               end
            end
            w = quiet ? 0 : $urandom_range(0, 7);
            rsp_wait <= w;
            rsp_ready <= (w == 0);
         end else if (rsp_wait > 0) begin
            rsp_wait <= rsp_wait - 1;
            rsp_ready <= (rsp_wait == 1);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      step_type t;
      int s, d;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_wdata = '0;
      node_limit_reg = 1023;
      edges_stored = 0;
      dropped_edge = 0;
      foreach (head_of[i]) head_of[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      steps.push_back(row_solve(1, 0, 0, 0));
      steps.push_back(row_cfg(0));
      steps.push_back(row_add(0, 1, 255));
      steps.push_back(row_solve(1, 1, 0, 0));
      steps.push_back(row_cfg(2));
      steps.push_back(row_solve(1, 1, 0, 0));
      steps.push_back(row_cfg(1023));
      steps.push_back(row_solve(1, 0, 255, 0));
      steps.push_back(row_add(1023, 1023, 0));
      steps.push_back(row_add(1, 2, 0));
      steps.push_back(row_add(2, 0, 1));
      steps.push_back(row_solve(0, 0, 0, 0));
      steps.push_back(row_cfg(3));
      steps.push_back(row_solve(0, 0, 0, 0));
      steps.push_back(row_add(682, 341, 170));
      steps.push_back(row_add(341, 682, 85));
      steps.push_back(row_cfg(1));
      steps.push_back(row_solve(0, 0, 0, 0));
      foreach (steps[i]) run_step(steps[i]);

      // reach past the directed cycle: each phase writes a fresh node count; edges persist
      for (int p = 0; p < 10; p++) begin
         quiet = (p == 3);
         case ($urandom_range(0, 3))
            0: t = row_cfg(1);
            1: t = row_cfg(2);
            default: t = row_cfg($urandom_range(3, 40));
         endcase
         run_step(t);
         for (int i = 0; i < 145; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               t = row_solve(0, 0, 0, 0);
            end else if ($urandom_range(0, 19) == 0) begin
               t = row_add($urandom_range(0, 1022), $urandom_range(0, 1022),
                           $urandom_range(0, 255));
            end else begin
               s = $urandom_range(0, 30);
               d = $urandom_range(s + 1, 31);
               if (p >= 7 && $urandom_range(0, 3) == 0) begin
                  t = row_add(d, s, $urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
               end else begin
                  t = row_add(s, d, $urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
               end
            end
            run_step(t);
         end
      end
      quiet = 0;

      run_step(row_cfg(3));
      run_step(row_add(0, 3, 200));
      run_step(row_solve(0, 0, 0, 0));
      req_valid <= 0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
